// ----- hw/rtl/rdtc_pkg.sv -----
// rdtc_pkg: types, codes and helpers shared by the connection state machine.
// Depends on nothing; used by rdtc_step and rdt_connection_fsm.
package rdtc_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_INITIAL_SEQUENCE = 1'b0,
        CFG_WINDOW_VALUE     = 1'b1
    } cfg_idx_t;

    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned SEQ_W      = 32;
    localparam int unsigned WIN_W      = 16;
    localparam int unsigned CODE_W     = 4;

    // Request kinds
    typedef enum logic [1:0] {
        REQ_OPEN         = 2'd0,
        REQ_CLOSE        = 2'd1,
        REQ_SEGMENT      = 2'd2,
        REQ_PASSIVE_CLOSE = 2'd3
    } req_t;

    // Received flags packed as {syn, ack, fin, other}; tests are exact matches
    localparam logic [3:0] FLG_SYN_ACK = 4'b1100;
    localparam logic [3:0] FLG_FIN_ACK = 4'b0110;
    localparam logic [3:0] FLG_ACK     = 4'b0100;
    localparam logic [3:0] FLG_FIN     = 4'b0010;

    // Connection states, one-hot
    typedef enum logic [8:0] {
        ST_CLOSED      = 9'b000000001,
        ST_SYNSENT     = 9'b000000010,
        ST_ESTABLISHED = 9'b000000100,
        ST_FINWAIT1    = 9'b000001000,
        ST_FINWAIT2    = 9'b000010000,
        ST_CLOSING     = 9'b000100000,
        ST_TIMEWAIT    = 9'b001000000,
        ST_CLOSEWAIT   = 9'b010000000,
        ST_LASTACK     = 9'b100000000
    } conn_st_t;

    // Reported state codes
    localparam logic [CODE_W-1:0] CODE_CLOSED      = 4'd0;
    localparam logic [CODE_W-1:0] CODE_SYNSENT     = 4'd1;
    localparam logic [CODE_W-1:0] CODE_ESTABLISHED = 4'd2;
    localparam logic [CODE_W-1:0] CODE_FINWAIT1    = 4'd3;
    localparam logic [CODE_W-1:0] CODE_FINWAIT2    = 4'd4;
    localparam logic [CODE_W-1:0] CODE_CLOSING     = 4'd5;
    localparam logic [CODE_W-1:0] CODE_TIMEWAIT    = 4'd6;
    localparam logic [CODE_W-1:0] CODE_CLOSEWAIT   = 4'd7;
    localparam logic [CODE_W-1:0] CODE_LASTACK     = 4'd8;

    typedef struct packed {
        logic [1:0]       req_type;
        logic             peer_syn;
        logic             peer_ack_flag;
        logic             peer_fin;
        logic             peer_other_flags;
        logic [SEQ_W-1:0] peer_seq;
        logic [SEQ_W-1:0] peer_ack_number;
    } rdtc_in_t;

    typedef struct packed {
        logic              send_valid;
        logic              send_syn;
        logic              send_ack;
        logic              send_fin;
        logic [SEQ_W-1:0]  send_seq;
        logic [SEQ_W-1:0]  send_ack_number;
        logic [WIN_W-1:0]  send_window;
        logic [CODE_W-1:0] conn_state;
    } rdtc_out_t;

    // Connection context carried between the register bank and the step logic
    typedef struct packed {
        conn_st_t         state;
        logic [SEQ_W-1:0] own_seq;
        logic [SEQ_W-1:0] ack_val;
    } rdtc_ctx_t;

    function automatic logic [CODE_W-1:0] state_code(input conn_st_t st);
        logic [CODE_W-1:0] code;
        unique case (st)
            ST_CLOSED:      code = CODE_CLOSED;
            ST_SYNSENT:     code = CODE_SYNSENT;
            ST_ESTABLISHED: code = CODE_ESTABLISHED;
            ST_FINWAIT1:    code = CODE_FINWAIT1;
            ST_FINWAIT2:    code = CODE_FINWAIT2;
            ST_CLOSING:     code = CODE_CLOSING;
            ST_TIMEWAIT:    code = CODE_TIMEWAIT;
            ST_CLOSEWAIT:   code = CODE_CLOSEWAIT;
            ST_LASTACK:     code = CODE_LASTACK;
            default:        code = CODE_CLOSED;
        endcase
        return code;
    endfunction

endpackage

// ----- hw/rtl/rdtc_step.sv -----
// rdtc_step: next connection context and sent header for one word.
// Depends on rdtc_pkg.
module rdtc_step (
    input  rdtc_pkg::rdtc_ctx_t          cur,
    input  logic [rdtc_pkg::WIN_W-1:0]   window,
    input  rdtc_pkg::rdtc_in_t           item,
    output rdtc_pkg::rdtc_ctx_t          nxt,
    output rdtc_pkg::rdtc_out_t          res
);

    logic [3:0]                 flags;
    logic [rdtc_pkg::SEQ_W-1:0] next_seq;
    logic [rdtc_pkg::SEQ_W-1:0] peer_seq_inc;
    logic                       ack_match;
    logic                       send;
    logic                       snd_syn;
    logic                       snd_ack;
    logic                       snd_fin;

    assign flags        = {item.peer_syn, item.peer_ack_flag, item.peer_fin,
                           item.peer_other_flags};
    assign next_seq     = cur.own_seq + rdtc_pkg::SEQ_W'(1);
    assign peer_seq_inc = item.peer_seq + rdtc_pkg::SEQ_W'(1);
    assign ack_match    = (item.peer_ack_number == next_seq);

    always_comb begin
        nxt     = cur;
        send    = 1'b0;
        snd_syn = 1'b0;
        snd_ack = 1'b0;
        snd_fin = 1'b0;
        unique case (rdtc_pkg::req_t'(item.req_type))
            rdtc_pkg::REQ_OPEN: begin
                if (cur.state == rdtc_pkg::ST_CLOSED) begin
                    send      = 1'b1;
                    snd_syn   = 1'b1;
                    nxt.state = rdtc_pkg::ST_SYNSENT;
                end
            end
            rdtc_pkg::REQ_CLOSE: begin
                if (cur.state == rdtc_pkg::ST_ESTABLISHED) begin
                    send      = 1'b1;
                    snd_fin   = 1'b1;
                    nxt.state = rdtc_pkg::ST_FINWAIT1;
                end
            end
            rdtc_pkg::REQ_PASSIVE_CLOSE: begin
                // Close-wait is passed through in the same word
                if (cur.state == rdtc_pkg::ST_ESTABLISHED) begin
                    nxt.ack_val = peer_seq_inc;
                    send        = 1'b1;
                    snd_fin     = 1'b1;
                    snd_ack     = 1'b1;
                    nxt.state   = rdtc_pkg::ST_LASTACK;
                end
            end
            rdtc_pkg::REQ_SEGMENT: begin
                unique case (cur.state)
                    rdtc_pkg::ST_SYNSENT: begin
                        send = 1'b1;
                        if (flags == rdtc_pkg::FLG_SYN_ACK && ack_match) begin
                            nxt.ack_val = peer_seq_inc;
                            snd_ack     = 1'b1;
                            nxt.state   = rdtc_pkg::ST_ESTABLISHED;
                        end else begin
                            snd_syn = 1'b1;
                        end
                    end
                    rdtc_pkg::ST_FINWAIT1: begin
                        priority if (flags == rdtc_pkg::FLG_FIN_ACK) begin
                            if (ack_match) begin
                                nxt.ack_val = peer_seq_inc;
                                nxt.own_seq = next_seq;
                                send        = 1'b1;
                                snd_ack     = 1'b1;
                                nxt.state   = rdtc_pkg::ST_FINWAIT2;
                            end
                        end else if (flags == rdtc_pkg::FLG_ACK) begin
                            nxt.state = rdtc_pkg::ST_FINWAIT2;
                        end else if (flags == rdtc_pkg::FLG_FIN) begin
                            send      = 1'b1;
                            snd_ack   = 1'b1;
                            nxt.state = rdtc_pkg::ST_CLOSING;
                        end
                    end
                    rdtc_pkg::ST_CLOSING: begin
                        if (flags == rdtc_pkg::FLG_ACK) begin
                            nxt.state = rdtc_pkg::ST_TIMEWAIT;
                        end
                    end
                    rdtc_pkg::ST_FINWAIT2: begin
                        if (flags == rdtc_pkg::FLG_FIN) begin
                            send      = 1'b1;
                            snd_ack   = 1'b1;
                            nxt.state = rdtc_pkg::ST_TIMEWAIT;
                        end
                    end
                    rdtc_pkg::ST_LASTACK: begin
                        if (flags == rdtc_pkg::FLG_ACK && ack_match) begin
                            nxt.state = rdtc_pkg::ST_CLOSED;
                        end
                    end
                    default: begin
                        nxt = cur;
                    end
                endcase
            end
            default: begin
                nxt = cur;
            end
        endcase
    end

    // Header fields read zero when nothing is sent
    always_comb begin
        res.send_valid      = send;
        res.send_syn        = snd_syn;
        res.send_ack        = snd_ack;
        res.send_fin        = snd_fin;
        res.send_seq        = send ? nxt.own_seq : '0;
        res.send_ack_number = send ? nxt.ack_val : '0;
        res.send_window     = send ? window : '0;
        res.conn_state      = rdtc_pkg::state_code(nxt.state);
    end

endmodule

// ----- hw/rtl/rdt_connection_fsm.sv -----
// rdt_connection_fsm: top level of the TCP-like connection state machine.
// Depends on rdtc_pkg and rdtc_step.
//
//  channel  | ports                          | direction | word
//  ---------+--------------------------------+-----------+---------------------------
//  request  | s_valid, s_ready, s_data       | in        | rdtc_in_t (command/segment)
//  result   | m_valid, m_ready, m_data       | out       | rdtc_out_t (header, state)
//  config   | cfg_we, cfg_index, cfg_wdata   | in        | initial sequence, window
//
// Each accepted word produces exactly one result word, registered in the next
// cycle; one word per cycle is sustained while m_ready stays high, set by the single
// pass from the context registers through rdtc_step into the result register.
// s_ready is high whenever the result register is empty or being drained,
// so a stalled m_ready holds one result and backs up the request channel.
// aresetn (synchronous, active low) returns to closed with all counters zero.
module rdt_connection_fsm (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [rdtc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rdtc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  rdtc_pkg::rdtc_in_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output rdtc_pkg::rdtc_out_t               m_data
);

    // Configuration register; the starting sequence lands straight in the context
    logic [rdtc_pkg::WIN_W-1:0] window_reg;

    // Connection context and result register
    rdtc_pkg::rdtc_ctx_t  ctx_reg;
    rdtc_pkg::rdtc_ctx_t  ctx_next;
    rdtc_pkg::rdtc_out_t  res_reg;
    rdtc_pkg::rdtc_out_t  res_next;
    logic                 res_valid_reg;
    logic                 accept;

    // Accept when the result slot is free or drains this cycle
    assign s_ready = !res_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    rdtc_step u_step (
        .cur    (ctx_reg),
        .window (window_reg),
        .item   (s_data),
        .nxt    (ctx_next),
        .res    (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg      <= '0;
            ctx_reg.state   <= rdtc_pkg::ST_CLOSED;
            ctx_reg.own_seq <= '0;
            ctx_reg.ack_val <= '0;
            res_valid_reg   <= 1'b0;
        end else begin
            // Advance the connection on every accepted word
            if (accept) begin
                ctx_reg <= ctx_next;
            end
            // The user must write config only while idle; the block itself does not
            // enforce it. A sequence write while closed also reloads the own sequence
            if (cfg_we) begin
                unique case (rdtc_pkg::cfg_idx_t'(cfg_index))
                    rdtc_pkg::CFG_INITIAL_SEQUENCE: begin
                        if (ctx_reg.state == rdtc_pkg::ST_CLOSED) begin
                            ctx_reg.own_seq <= cfg_wdata[rdtc_pkg::SEQ_W-1:0];
                        end
                    end
                    rdtc_pkg::CFG_WINDOW_VALUE: begin
                        window_reg <= cfg_wdata[rdtc_pkg::WIN_W-1:0];
                    end
                    default: begin
                        window_reg <= window_reg;
                    end
                endcase
            end
            // Hold the result until taken; drop the flag once drained
            if (accept) begin
                res_valid_reg <= 1'b1;
            end else if (m_ready) begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload: load on accept, hold while stalled
    always_ff @(posedge aclk) begin
        if (accept) begin
            res_reg <= res_next;
        end
    end

    assign m_valid = res_valid_reg;
    assign m_data  = res_reg;

endmodule
